// ===== hdl/ald_pkg.sv =====
// Shared types and constants for the resistor-ladder option decoder.
// Used by ald_ctrl, ald_dp and analog_ladder_option_decoder_unit; no dependencies.
package ald_pkg;

    // Converter word and derived widths
    localparam int SAMPLE_BITS = 10;
    localparam int FULL_SCALE  = 1 << SAMPLE_BITS;
    localparam int SUM_W       = SAMPLE_BITS + 4;   // holds up to 16 full-scale samples
    localparam int LOW_W       = SAMPLE_BITS + 1;   // minimum tracker starts at full scale
    localparam int DIV_W       = 5;                 // divisor up to 16
    localparam int DCNT_W      = $clog2(SUM_W);
    localparam int PT_W        = SAMPLE_BITS + 2;   // step points plus half-window
    localparam int ZONE_W      = SAMPLE_BITS - 1;
    localparam int OPT_W       = 4;

    // Configuration port
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_OPTION_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LIMIT = 2'd1;

    localparam logic [OPT_W-1:0] OPTION_COUNT_RST = 4'd4;
    localparam logic [CFG_W-1:0] SPREAD_LIMIT_RST = 10'd50;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic load_mean;
        logic load_step;
        logic div_step;
        logic search_init;
        logic search_step;
        logic out_load;
    } ald_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_sample;
        logic div_last;
        logic hit;
        logic at_top;
        logic out_free;
    } ald_status_t;

endpackage

// ===== hdl/analog_ladder_option_decoder_unit.sv =====
// Top level of the resistor-ladder option decoder: controller plus datapath.
// Depends on ald_pkg, ald_ctrl and ald_dp.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   adc_sample
//   out      output     out_valid/out_stall option_index, batch_value, was_noisy
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// A sample that does not end a batch is only accumulated. The last sample of a
// batch is followed by the mean, the divider load, the restoring divider for the
// step size, the start of the window search and a walk over the options searched;
// the input stalls until the search misses or its result is loaded.
// Reset is asynchronous and active low; the batch restarts empty.
// A result waiting under out_stall still lets samples in; only a new result
// waits for the output word to be taken.
module analog_ladder_option_decoder_unit #(
    parameter int SAMPLES_PER_READ = 10,
    parameter int MAX_OPTIONS      = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ald_pkg::SAMPLE_BITS-1:0]  adc_sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ald_pkg::OPT_W-1:0]        option_index,
    output logic [ald_pkg::SAMPLE_BITS-1:0]  batch_value,
    output logic                             was_noisy,
    input  logic                             cfg_we,
    input  logic [ald_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ald_pkg::CFG_W-1:0]        cfg_data
);
    import ald_pkg::*;

    ald_cmd_t    cmd;
    ald_status_t status;

    ald_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ald_dp #(
        .SAMPLES_PER_READ (SAMPLES_PER_READ),
        .MAX_OPTIONS      (MAX_OPTIONS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .adc_sample   (adc_sample),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .option_index (option_index),
        .batch_value  (batch_value),
        .was_noisy    (was_noisy)
    );

endmodule

// ===== hdl/ald_ctrl.sv =====
// Sequencer for the option decoder: batch collection, mean, step division, window search.
// Depends on ald_pkg for the command and status structs.
module ald_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ald_pkg::ald_status_t status,
    output ald_pkg::ald_cmd_t    cmd
);
    import ald_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN_LOAD,
        S_STEP_LOAD,
        S_STEP_DIV,
        S_SEARCH_INIT,
        S_SEARCH,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg;

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.accept = 1'b1;
                    if (status.last_sample)
                        state_next = S_MEAN_LOAD;
                end
            end
            S_MEAN_LOAD:
            begin
                cmd.load_mean = 1'b1;
                state_next    = S_STEP_LOAD;
            end
            S_STEP_LOAD:
            begin
                cmd.load_step = 1'b1;
                state_next    = S_STEP_DIV;
            end
            S_STEP_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_SEARCH_INIT;
            end
            S_SEARCH_INIT:
            begin
                cmd.search_init = 1'b1;
                state_next      = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (status.hit)
                    state_next = S_EMIT;
                else if (status.at_top)
                    state_next = S_IDLE;
                else
                    cmd.search_step = 1'b1;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the registered input stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

`ifndef ASSERT_OFF
    a_last_starts_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.last_sample) |=> cmd.load_mean)
        else $error("batch end did not start the mean");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a word still waiting");

    a_search_step_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_step |-> (!status.hit && !status.at_top))
        else $error("search advanced past a hit or the last option");
`endif

endmodule

// ===== hdl/ald_dp.sv =====
// Datapath for the option decoder: batch accumulators, reciprocal multiply for the
// mean, restoring divider for the step size, window search and the output word
// register. Depends on ald_pkg.
module ald_dp #(
    parameter int SAMPLES_PER_READ = 10,
    parameter int MAX_OPTIONS      = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ald_pkg::ald_cmd_t                cmd,
    output ald_pkg::ald_status_t             status,
    input  logic [ald_pkg::SAMPLE_BITS-1:0]  adc_sample,
    input  logic                             cfg_we,
    input  logic [ald_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ald_pkg::CFG_W-1:0]        cfg_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ald_pkg::OPT_W-1:0]        option_index,
    output logic [ald_pkg::SAMPLE_BITS-1:0]  batch_value,
    output logic                             was_noisy
);
    import ald_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES_PER_READ + 1);
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(SAMPLES_PER_READ - 1);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(SAMPLES_PER_READ);
    localparam logic [OPT_W-1:0] OPTION_CAP = OPT_W'(MAX_OPTIONS - 1);

    // Mean by reciprocal: exact for every sum below 2^SUM_W and batch length up to 16
    localparam int MEAN_SHIFT = SUM_W + 4;
    localparam int MEAN_RECIP = ((1 << MEAN_SHIFT) + SAMPLES_PER_READ - 1) / SAMPLES_PER_READ;
    localparam int PROD_W     = SUM_W + MEAN_SHIFT + 1;

    // Configuration registers
    logic [OPT_W-1:0] option_count_reg;
    logic [CFG_W-1:0] spread_limit_reg;

    // Batch accumulators
    logic [CNT_W-1:0]       count_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [LOW_W-1:0]       low_reg;
    logic [SAMPLE_BITS-1:0] high_reg;

    // Divider
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  divisor_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [DIV_W:0]    rem_shift;
    logic              rem_ge;

    // Mean
    logic [PROD_W-1:0] mean_prod;

    // Search
    logic                   noisy_reg;
    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS:0]   step_reg;
    logic [ZONE_W-1:0]      zone_reg;
    logic [PT_W-1:0]        point_reg;
    logic [OPT_W-1:0]       k_reg;
    logic [OPT_W-1:0]       top_reg;
    logic [PT_W-1:0]        value_ext, zone_ext;

    // Output word
    logic                   out_valid_reg;
    logic [OPT_W-1:0]       option_index_reg;
    logic [SAMPLE_BITS-1:0] batch_value_reg;
    logic                   was_noisy_reg;

    logic [LOW_W-1:0] sample_ext;
    logic [LOW_W-1:0] spread;
    logic             noisy_now;

    assign sample_ext = {1'b0, adc_sample};
    assign spread     = {1'b0, high_reg} - low_reg;
    assign noisy_now  = spread > {1'b0, spread_limit_reg};

    // Truncated mean of the batch sum
    assign mean_prod = PROD_W'(sum_reg) * PROD_W'(MEAN_RECIP);

    // One restoring divider step
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};
    always_comb
    begin
        quo_next = {quo_reg[SUM_W-2:0], rem_ge};
        if (rem_ge)
            rem_next = DIV_W'(rem_shift - {1'b0, divisor_reg});
        else
            rem_next = rem_shift[DIV_W-1:0];
    end

    // Window test at the current step point
    assign value_ext = PT_W'(value_reg);
    assign zone_ext  = PT_W'(zone_reg);

    always_comb
    begin
        status.last_sample = (count_reg == CNT_LAST);
        status.div_last    = (dcnt_reg == '0);
        status.hit         = ((value_ext + zone_ext) > point_reg)
                          && (value_ext < (point_reg + zone_ext));
        status.at_top      = (k_reg == top_reg);
        status.out_free    = !out_valid_reg || !out_stall;
    end

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            option_count_reg <= OPTION_COUNT_RST;
            spread_limit_reg <= SPREAD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OPTION_COUNT: option_count_reg <= cfg_data[OPT_W-1:0];
                REG_SPREAD_LIMIT: spread_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Accumulate the batch; clear it when the mean is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            low_reg   <= LOW_W'(FULL_SCALE);
            high_reg  <= '0;
        end
        else if (cmd.load_mean)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            low_reg   <= LOW_W'(FULL_SCALE);
            high_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            count_reg <= count_reg + CNT_W'(1);
            sum_reg   <= sum_reg + SUM_W'(adc_sample);
            if (sample_ext < low_reg)
                low_reg <= sample_ext;
            if (adc_sample > high_reg)
                high_reg <= adc_sample;
        end
    end

    // Latch the batch value and noise flag; load and advance the step divider
    always_ff @(posedge clk)
    begin
        if (cmd.load_mean)
        begin
            value_reg <= noisy_now ? '0 : mean_prod[MEAN_SHIFT +: SAMPLE_BITS];
            noisy_reg <= noisy_now;
        end
        else if (cmd.load_step)
        begin
            quo_reg     <= SUM_W'(FULL_SCALE);
            rem_reg     <= '0;
            divisor_reg <= DIV_W'(option_count_reg) + DIV_W'(1);
            dcnt_reg    <= DCNT_W'(SUM_W - 1);
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    // Walk the step points one option a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            step_reg  <= quo_reg[SAMPLE_BITS:0];
            zone_reg  <= quo_reg[SAMPLE_BITS:2];
            point_reg <= '0;
            k_reg     <= '0;
            top_reg   <= (option_count_reg > OPTION_CAP) ? OPTION_CAP : option_count_reg;
        end
        else if (cmd.search_step)
        begin
            point_reg <= point_reg + PT_W'(step_reg);
            k_reg     <= k_reg + OPT_W'(1);
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            option_index_reg <= k_reg;
            batch_value_reg  <= value_reg;
            was_noisy_reg    <= noisy_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign option_index = option_index_reg;
    assign batch_value  = batch_value_reg;
    assign was_noisy    = was_noisy_reg;

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("batch counter ran past the batch length");

    a_low_below_high: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (low_reg <= {1'b0, high_reg}))
        else $error("batch minimum above batch maximum");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled output word dropped");
`endif

endmodule

// ===== sim/analog_ladder_option_decoder_unit_tb.sv =====
// Self-checking bench for analog_ladder_option_decoder_unit: a batch predictor
// checks every output word while the input idles and the output stalls at random.
// Depends on ald_pkg and the decoder RTL.
module analog_ladder_option_decoder_unit_tb;
    import ald_pkg::*;

    localparam int BATCH_LEN     = 10;
    localparam int OPTION_CAP    = 16;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 500;
    localparam int CYCLE_LIMIT   = 200000;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {SHAPE_CLEAN, SHAPE_GAP, SHAPE_NOISY, SHAPE_WILD} batch_shape_t;

    typedef struct packed {
        logic [OPT_W-1:0]       option;
        logic [SAMPLE_BITS-1:0] value;
        logic                   noisy;
    } decode_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] adc_sample   = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic [OPT_W-1:0]       option_index;
    logic [SAMPLE_BITS-1:0] batch_value;
    logic                   was_noisy;
    logic                   cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [CFG_W-1:0]       cfg_data     = '0;

    // Bench control
    logic                   in_taken     = 1'b0;
    logic                   calm         = 1'b0;
    logic                   hold_arm     = 1'b0;
    logic                   hold_done    = 1'b0;
    int                     hold_left    = 0;
    int                     cycle_count  = 0;
    int                     mismatches   = 0;

    logic [SAMPLE_BITS-1:0] pending_samples[$];
    decode_t                expected_decodes[$];

    // Predictor copy of registers and batch state
    int unsigned opt_count  = OPTION_COUNT_RST;
    int unsigned spread_lim = SPREAD_LIMIT_RST;
    int unsigned batch_cnt  = 0;
    int unsigned acc_sum    = 0;
    int unsigned low_mark   = FULL_SCALE;
    int unsigned high_mark  = 0;

    analog_ladder_option_decoder_unit #(
        .SAMPLES_PER_READ (BATCH_LEN),
        .MAX_OPTIONS      (OPTION_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .adc_sample   (adc_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .option_index (option_index),
        .batch_value  (batch_value),
        .was_noisy    (was_noisy),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Fold one sample into the batch; at batch end decode the mean and queue the word if a window holds it
    task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] s);
        int unsigned mean;
        int unsigned step;
        int unsigned zone;
        int unsigned top;
        int unsigned point;
        int unsigned k;
        bit          noisy;
        bit          found;
        decode_t     word;
        if (s < low_mark)
            low_mark = s;
        if (s > high_mark)
            high_mark = s;
        acc_sum += s;
        batch_cnt++;
        if (batch_cnt == BATCH_LEN)
        begin
            mean  = acc_sum / BATCH_LEN;
            noisy = (high_mark - low_mark) > spread_lim;
            if (noisy)
                mean = 0;
            batch_cnt = 0;
            acc_sum   = 0;
            low_mark  = FULL_SCALE;
            high_mark = 0;
            step  = FULL_SCALE / (opt_count + 1);
            zone  = step / 4;
            top   = (opt_count > OPTION_CAP - 1) ? OPTION_CAP - 1 : opt_count;
            found = 1'b0;
            // Take the first window that holds the mean
            for (k = 0; k <= top; k++)
            begin
                point = k * step;
                if (!found && mean + zone > point && mean < point + zone)
                begin
                    found       = 1'b1;
                    word.option = k[OPT_W-1:0];
                    word.value  = mean[SAMPLE_BITS-1:0];
                    word.noisy  = noisy;
                    expected_decodes.push_back(word);
                end
            end
        end
    endtask

    function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input int v);
        if (v < 0)
            return '0;
        if (v > FULL_SCALE - 1)
            return '1;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Build one batch of samples shaped to hit, miss or upset the windows
    task automatic queue_batch(input batch_shape_t shape);
        int unsigned step;
        int unsigned zone;
        int unsigned k;
        int          center;
        int          half;
        int          i;
        step   = FULL_SCALE / (opt_count + 1);
        zone   = step / 4;
        k      = $urandom_range(opt_count);
        half   = (spread_lim / 2 < 8) ? spread_lim / 2 : 8;
        if ($urandom_range(3) == 0)
            half = 0;
        center = 0;
        if (shape == SHAPE_CLEAN)
            center = int'(k * step) - int'(zone) + 1 + int'($urandom_range(2 * zone - 2));
        else if (shape == SHAPE_GAP)
            center = int'(k * step + zone) + int'($urandom_range(step - 2 * zone));
        for (i = 0; i < BATCH_LEN; i++)
        begin
            case (shape)
                SHAPE_CLEAN, SHAPE_GAP:
                    pending_samples.push_back(
                        clamp_sample(center - half + int'($urandom_range(2 * half))));
                SHAPE_NOISY:
                    pending_samples.push_back(i == 0 ? '0 : (i == 1 ? '1 :
                        SAMPLE_BITS'($urandom_range(FULL_SCALE - 1))));
                default:
                    pending_samples.push_back(SAMPLE_BITS'($urandom_range(FULL_SCALE - 1)));
            endcase
        end
    endtask

    task automatic random_batches(input int count);
        int          n;
        int unsigned pick;
        @(posedge clk);
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                queue_batch(SHAPE_CLEAN);
            else if (pick < 80)
                queue_batch(SHAPE_GAP);
            else if (pick < 90)
                queue_batch(SHAPE_NOISY);
            else
                queue_batch(SHAPE_WILD);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Wait until every sample is in, every word is out, and the decoder has drained
    task automatic settle();
        while (pending_samples.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_decodes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Drive input words; hold a stalled word, otherwise offer the next or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 10))
            begin
                adc_sample <= pending_samples.pop_front();
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the output at random, with one long hold-off when armed
    always @(negedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 10);
    end

    // Check output words, track register writes and predict from accepted samples
    always @(posedge clk)
    begin : word_monitor
        decode_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_decodes.size() == 0)
                begin
                    $error("unexpected output word: option_index %0d batch_value %0d was_noisy %0d",
                           option_index, batch_value, was_noisy);
                    mismatches++;
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    if (option_index !== want.option)
                    begin
                        $error("option_index: expected %0d, actual %0d", want.option, option_index);
                        mismatches++;
                    end
                    if (batch_value !== want.value)
                    begin
                        $error("batch_value: expected %0d, actual %0d", want.value, batch_value);
                        mismatches++;
                    end
                    if (was_noisy !== want.noisy)
                    begin
                        $error("was_noisy: expected %0d, actual %0d", want.noisy, was_noisy);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OPTION_COUNT: opt_count  = cfg_data[OPT_W-1:0];
                    REG_SPREAD_LIMIT: spread_lim = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                absorb_sample(adc_sample);
            in_taken <= in_valid && !in_stall;
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : sequencer
        int p;
        int i;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: full-scale batch past the top window, then a noisy batch
        @(posedge clk);
        repeat (BATCH_LEN) pending_samples.push_back('1);
        for (i = 0; i < BATCH_LEN; i++)
            pending_samples.push_back((i % 2) ? '1 : '0);
        settle();

        // Writes past the last register leave the reset settings in place
        write_reg(REG_SPARE_A, CFG_W'($urandom));
        write_reg(REG_SPARE_B, '1);
        random_batches(10);
        settle();

        // Option count zero, widest spread; the output holds off so the input backs up
        write_reg(REG_OPTION_COUNT, {6'($urandom), 4'd0});
        write_reg(REG_SPREAD_LIMIT, 10'd1023);
        hold_arm <= 1'b1;
        random_batches(12);
        settle();

        // Most options, zero spread
        write_reg(REG_OPTION_COUNT, {6'($urandom), 4'd15});
        write_reg(REG_SPREAD_LIMIT, 10'd0);
        random_batches(15);
        settle();

        // Option count one, with no idling on either side
        write_reg(REG_OPTION_COUNT, 10'd1);
        write_reg(REG_SPREAD_LIMIT, 10'd20);
        calm <= 1'b1;
        random_batches(10);
        settle();
        calm <= 1'b0;

        // Random settings
        for (p = 0; p < 6; p++)
        begin
            write_reg(REG_OPTION_COUNT, CFG_W'($urandom));
            write_reg(REG_SPREAD_LIMIT, ($urandom_range(3) == 0) ?
                      CFG_W'($urandom_range(1023)) : CFG_W'($urandom_range(100)));
            random_batches(9);
            settle();
        end

        if (expected_decodes.size() != 0)
        begin
            $error("%0d expected output words never arrived", expected_decodes.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ald_pkg.sv
hdl/ald_ctrl.sv
hdl/ald_dp.sv
hdl/analog_ladder_option_decoder_unit.sv
sim/analog_ladder_option_decoder_unit_tb.sv
